/* hw/rtl/sha256_hash_engine_macros.svh */
// Assertion macros for the SHA-256 hash engine.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH

// same-cycle implication, off during reset
`define SHA_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SHA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sha_pkg.sv */
// Shared types, constants and tables for the SHA-256 hash engine.
// No dependencies.
`default_nettype none

package sha_pkg;

   localparam int unsigned NumWords   = 8;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned NumRounds  = 64;
   localparam int unsigned LenOffset  = 56;   // first byte of the length field
   localparam logic [7:0]  PadMark    = 8'h80;

   typedef logic [31:0] sha_word_type;

   // per-cycle commands from the sequencer to the round datapath
   typedef struct packed {
      logic load;     // working vars <= hash words
      logic round;    // one compression round
      logic fold;     // hash words += working vars
      logic reinit;   // hash words <= initial values
   } sha_core_ctl_type;

   function automatic sha_word_type sha_rotr(input sha_word_type x, input int unsigned k);
      return 32'({x, x} >> k);
   endfunction

   function automatic sha_word_type sha_init_hash(input logic [2:0] idx);
      sha_word_type v;
      case (idx)
         3'd0:    v = 32'h6a09e667;
         3'd1:    v = 32'hbb67ae85;
         3'd2:    v = 32'h3c6ef372;
         3'd3:    v = 32'ha54ff53a;
         3'd4:    v = 32'h510e527f;
         3'd5:    v = 32'h9b05688c;
         3'd6:    v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic sha_word_type sha_round_k(input logic [5:0] idx);
      sha_word_type v;
      case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;
         default: v = 32'hc67178f2;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sha_chan_if.sv */
// Valid/ready channel interfaces for the SHA-256 hash engine.
// Request channel carries message bytes, response channel digest words.
`default_nettype none

interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       message_end;

   modport source (output valid, output data_byte, output byte_present,
                   output message_end, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input message_end, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sha_msg_window.sv */
// Block buffer and message schedule: 16-word window, byte-filled, then shifted.
// Depends on sha_pkg.
`default_nettype none

module sha_msg_window (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [5:0]         wr_pos,
   input  logic [7:0]         wr_byte,
   input  logic               shift_en,
   output sha_pkg::sha_word_type w_cur
);
   import sha_pkg::*;

   logic [3:0][7:0] win_ff [16];
   logic [3:0][7:0] win_in [16];
   sha_word_type    w_next;

   function automatic sha_word_type ssig0(input sha_word_type x);
      return sha_rotr(x, 7) ^ sha_rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic sha_word_type ssig1(input sha_word_type x);
      return sha_rotr(x, 17) ^ sha_rotr(x, 19) ^ (x >> 10);
   endfunction

   // W[t+16] from the window holding W[t..t+15]
   assign w_next = ssig1(win_ff[14]) + win_ff[9] + ssig0(win_ff[1]) + win_ff[0];
   assign w_cur  = win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (shift_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_next;
      end else if (wr_en) begin
         // big-endian: byte 0 of a word lands in bits 31:24
         win_in[wr_pos[5:2]][~wr_pos[1:0]] = wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/sha_round_core.sv */
// Compression datapath: working variables a..h, hash words, one round per cycle.
// Depends on sha_pkg.
`default_nettype none

module sha_round_core (
   input  logic                      clock,
   input  logic                      reset,
   input  sha_pkg::sha_core_ctl_type ctl,
   input  sha_pkg::sha_word_type     k_val,
   input  sha_pkg::sha_word_type     w_val,
   input  logic [2:0]                rd_idx,
   output sha_pkg::sha_word_type     rd_word
);
   import sha_pkg::*;

   sha_word_type work_ff [8];
   sha_word_type work_in [8];
   sha_word_type hash_ff [8];
   sha_word_type hash_in [8];
   sha_word_type big1, pick, big0, vote, t1, t2;

   assign big1 = sha_rotr(work_ff[4], 6) ^ sha_rotr(work_ff[4], 11) ^ sha_rotr(work_ff[4], 25);
   assign pick = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign big0 = sha_rotr(work_ff[0], 2) ^ sha_rotr(work_ff[0], 13) ^ sha_rotr(work_ff[0], 22);
   assign vote = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]);
   assign t1   = work_ff[7] + big1 + pick + k_val + w_val;
   assign t2   = big0 + vote;

   assign rd_word = hash_ff[rd_idx];

   always_comb begin
      work_in = work_ff;
      hash_in = hash_ff;
      if (ctl.load) begin
         work_in = hash_ff;
      end else if (ctl.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (ctl.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end else if (ctl.reinit) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = sha_init_hash(3'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha_init_hash(3'(i));
         end
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/sha256_hash_engine.sv */
// SHA-256 hash engine top level: request sequencer, padding, digest output.
// Depends on sha_pkg, sha_chan_if, sha_msg_window, sha_round_core and the macro header.
//
//   channel   dir  handshake           payload
//   req_chan  in   valid/ready         data_byte[7:0], byte_present, message_end
//   rsp_chan  out  valid/ready         digest_word[31:0], word_index[2:0], last_word
//
// A byte request that does not complete a block leaves ready high.
// A full 64-byte block holds off requests through load, 64 rounds on the
// single round unit, and fold. A message end adds the padding bytes, one per cycle
// up to the block end, one or two compressions, and the hand-out of the 8 digest words.
// Synchronous active-high reset returns to the initial hash with an empty message.
// The response register holds its word while rsp ready is low; the sequencer waits.
`default_nettype none

`include "sha256_hash_engine_macros.svh"

module sha256_hash_engine (
   input logic        clock,
   input logic        reset,
   sha_req_if.sink    req_chan,
   sha_rsp_if.source  rsp_chan
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,    // taking requests
      ST_PAD,     // writing one padding byte per cycle
      ST_LOAD,    // copy hash words into working vars
      ST_ROUND,   // 64 rounds
      ST_FOLD,    // add working vars back into the hash
      ST_OUT      // hand out digest words
   } state_type;

   state_type    state_ff, state_in;
   logic [5:0]   fill_ff, fill_in;       // bytes in the current block
   logic [63:0]  bits_ff, bits_in;       // message length in bits, wraps
   logic [5:0]   round_ff, round_in;
   logic         end_ff, end_in;         // message end seen, padding owed
   logic         mark_ff, mark_in;       // 0x80 marker still to write
   logic         mark_hi_ff, mark_hi_in; // marker landed at or past the length slot start
   logic         final_ff, final_in;     // block being compressed holds the length
   logic [2:0]   out_idx_ff, out_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   sha_word_type rsp_word_ff, rsp_word_in;
   logic [2:0]   rsp_idx_ff, rsp_idx_in;
   logic         rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             rsp_take;
   logic             len_slot;
   logic [7:0][7:0]  len_bytes;
   logic [7:0]       pad_byte;
   logic             win_wr;
   logic [7:0]       win_byte;
   sha_word_type     w_cur;
   sha_word_type     hash_word;
   sha_core_ctl_type core_ctl;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // output register is free, or its word leaves this cycle
   assign rsp_take = !rsp_valid_ff || rsp_chan.ready;

   // length bytes go into the last eight slots of the final block only,
   // never into a block that also took the marker past the slot start
   assign len_bytes = bits_ff;
   assign len_slot  = (fill_ff >= 6'(LenOffset)) && !mark_hi_ff && !mark_ff;
   assign pad_byte  = mark_ff  ? PadMark :
                      len_slot ? len_bytes[~fill_ff[2:0]] : 8'h00;

   assign win_wr   = (req_accept && req_chan.byte_present) || (state_ff == ST_PAD);
   assign win_byte = (state_ff == ST_PAD) ? pad_byte : req_chan.data_byte;

   assign core_ctl.load   = (state_ff == ST_LOAD);
   assign core_ctl.round  = (state_ff == ST_ROUND);
   assign core_ctl.fold   = (state_ff == ST_FOLD);
   assign core_ctl.reinit = (state_ff == ST_OUT) && rsp_take
                            && (out_idx_ff == 3'(NumWords - 1));

   sha_msg_window u_window (
      .clock    (clock),
      .wr_en    (win_wr),
      .wr_pos   (fill_ff),
      .wr_byte  (win_byte),
      .shift_en (state_ff == ST_ROUND),
      .w_cur    (w_cur)
   );

   sha_round_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (core_ctl),
      .k_val   (sha_round_k(round_ff)),
      .w_val   (w_cur),
      .rd_idx  (out_idx_ff),
      .rd_word (hash_word)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      end_in       = end_ff;
      mark_in      = mark_ff;
      mark_hi_in   = mark_hi_ff;
      final_in     = final_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.byte_present) begin
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               if (req_chan.message_end) begin
                  end_in  = 1'b1;
                  mark_in = 1'b1;
               end
               // a byte that fills the block is compressed before any padding
               if (req_chan.byte_present && fill_ff == 6'(BlockBytes - 1)) begin
                  state_in = ST_LOAD;
               end else if (req_chan.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            fill_in = fill_ff + 6'd1;
            mark_in = 1'b0;
            if (mark_ff && fill_ff >= 6'(LenOffset)) begin
               mark_hi_in = 1'b1;
            end
            if (fill_ff == 6'(BlockBytes - 1)) begin
               final_in = len_slot;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            round_in = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(NumRounds - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            mark_hi_in = 1'b0;
            if (final_ff) begin
               final_in   = 1'b0;
               end_in     = 1'b0;
               out_idx_in = 3'd0;
               state_in   = ST_OUT;
            end else if (end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = hash_word;
               rsp_idx_in   = out_idx_ff;
               rsp_last_in  = (out_idx_ff == 3'(NumWords - 1));
               out_idx_in   = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'(NumWords - 1)) begin
                  // hash words reinit in the core this same cycle
                  fill_in  = 6'd0;
                  bits_in  = 64'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= 6'd0;
         bits_ff      <= 64'd0;
         round_ff     <= 6'd0;
         end_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         mark_hi_ff   <= 1'b0;
         final_ff     <= 1'b0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         end_ff       <= end_in;
         mark_ff      <= mark_in;
         mark_hi_ff   <= mark_hi_in;
         final_ff     <= final_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_idx_ff;
   assign rsp_chan.last_word   = rsp_last_ff;

   // last_word flags the final digest word and nothing else
   `SHA_ASSERT_IMPL(a_last_idx, rsp_chan.valid && rsp_chan.last_word, rsp_chan.word_index == 3'd7, "last_word on wrong index")
   // every accepted byte advances the block fill by one
   `SHA_ASSERT_NEXT(a_fill_step, req_accept && req_chan.byte_present, fill_ff == $past(fill_ff) + 6'd1, "fill count did not advance")
   // the length-carrying block always leads to digest output
   `SHA_ASSERT_NEXT(a_final_out, state_ff == ST_FOLD && final_ff, state_ff == ST_OUT, "final block did not start output")
   // after the last word the message state is clean
   `SHA_ASSERT_NEXT(a_done_clear, core_ctl.reinit, state_ff == ST_IDLE && fill_ff == 6'd0 && bits_ff == 64'd0, "message state not cleared")

endmodule

`default_nettype wire

/* sim/sha256_hash_engine_checker.sv */
`timescale 1ns / 100ps
// Digest checker for sha256_hash_engine: watches both channels, predicts each digest
// and compares every response word in order. Depends on sha_pkg and sha_chan_if.

module sha256_hash_engine_checker (
   input  logic clock,
   input  logic reset,
   sha_req_if   req_mon,
   sha_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   words_due
);
   import sha_pkg::*;

   typedef struct packed {
      sha_word_type digest_word;
      logic [2:0]   word_index;
      logic         last_word;
   } digest_entry_type;

   localparam sha_word_type IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam sha_word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   sha_word_type     digest_state [8];
   logic [7:0]       block_bytes [64];
   logic [5:0]       byte_fill;
   logic [63:0]      bit_length;
   digest_entry_type digest_words_due [$];

   function automatic sha_word_type rotr32(input sha_word_type x, input int k);
      return (x >> k) | (x << (32 - k));
   endfunction

   function automatic void restart_message();
      digest_state = IV_WORDS;
      byte_fill    = '0;
      bit_length   = '0;
   endfunction

   // one 64-round compression of block_bytes into digest_state
   function automatic void fold_block();
      sha_word_type sched [64];
      sha_word_type w [8];
      sha_word_type s0, s1, t1, t2;
      int           i;
      for (i = 0; i < 16; i++)
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                     block_bytes[4*i+2], block_bytes[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      w = digest_state;
      for (i = 0; i < 64; i++) begin
         t1 = w[7] + (rotr32(w[4], 6) ^ rotr32(w[4], 11) ^ rotr32(w[4], 25))
            + ((w[4] & w[5]) ^ (~w[4] & w[6])) + ROUND_K[i] + sched[i];
         t2 = (rotr32(w[0], 2) ^ rotr32(w[0], 13) ^ rotr32(w[0], 22))
            + ((w[0] & w[1]) ^ (w[0] & w[2]) ^ (w[1] & w[2]));
         w[7] = w[6];
         w[6] = w[5];
         w[5] = w[4];
         w[4] = w[3] + t1;
         w[3] = w[2];
         w[2] = w[1];
         w[1] = w[0];
         w[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++)
         digest_state[i] = digest_state[i] + w[i];
   endfunction

   function automatic void absorb_request(input logic [7:0] data_byte,
                                          input logic byte_present,
                                          input logic message_end);
      int n;
      if (byte_present) begin
         block_bytes[byte_fill] = data_byte;
         byte_fill  = byte_fill + 6'd1;
         bit_length = bit_length + 64'd8;
         if (byte_fill == 6'd0)
            fold_block();
      end
      if (message_end) begin
         block_bytes[byte_fill] = 8'h80;
         for (n = byte_fill + 1; n < 64; n++)
            block_bytes[n] = 8'h00;
         // no room for the length field: spill into an extra block
         if (byte_fill >= 6'd56) begin
            fold_block();
            for (n = 0; n < 64; n++)
               block_bytes[n] = 8'h00;
         end
         for (n = 0; n < 8; n++)
            block_bytes[56+n] = bit_length[63-8*n -: 8];
         fold_block();
         for (n = 0; n < 8; n++)
            digest_words_due.push_back('{digest_state[n], 3'(n), (n == 7)});
         restart_message();
      end
   endfunction

   always @(posedge clock) begin
      digest_entry_type due;
      if (reset) begin
         restart_message();
         for (int n = 0; n < 64; n++)
            block_bytes[n] = 8'h00;
         digest_words_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_words_due.size() == 0) begin
               $display("%0t: unexpected digest word %h index %0d last %b", $time,
                        rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word);
               mismatch_count++;
            end else begin
               due = digest_words_due.pop_front();
               if (rsp_mon.digest_word !== due.digest_word ||
                   rsp_mon.word_index !== due.word_index ||
                   rsp_mon.last_word !== due.last_word) begin
                  $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           $time, due.digest_word, due.word_index, due.last_word,
                           rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_request(req_mon.data_byte, req_mon.byte_present, req_mon.message_end);
      end
      words_due = digest_words_due.size();
   end

endmodule

/* sim/sha256_hash_engine_tb.sv */
`timescale 1ns / 100ps
// Testbench top for sha256_hash_engine: clock, reset, request and response traffic,
// watchdog and verdict. Depends on sha_pkg, sha_chan_if and sha256_hash_engine_checker.

module sha256_hash_engine_tb;

   localparam int STALL_LIMIT  = 5000;  // cycles with no handshake on either channel
   localparam int PHASE_TARGET = 60;    // requests that carry a byte or an end, per phase
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 300;   // quiet time after the last digest word

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   rsp_hold_left;
   int   requests_sent;
   int   mismatch_count;
   int   words_due;
   int   quiet_cycles;

   sha_req_if req_chan ();
   sha_rsp_if rsp_chan ();

   sha256_hash_engine uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicts and compares; hands back the mismatch count and the words still due
   sha256_hash_engine_checker digest_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: ready changes at the falling edge. A hold-off, when armed,
   // keeps ready low for a counted stretch regardless of the idle rate.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any handshake clears the count; a long silence ends the run.
   initial begin
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Offers one request, starting at a falling edge, with random idle cycles first.
   // Returns at the falling edge after acceptance, valid still high.
   task automatic push_request(input logic [7:0] data_byte, input logic byte_present,
                               input logic message_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.data_byte    <= data_byte;
      req_chan.byte_present <= byte_present;
      req_chan.message_end  <= message_end;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      if (byte_present || message_end)
         requests_sent++;
   endtask

   // A message of len bytes. The end flag rides on the last byte half the time,
   // otherwise it comes as a request of its own. Ignored requests are mixed in.
   task automatic send_message(input int len);
      int k;
      bit tail_byte;
      tail_byte = (len > 0) && ($urandom_range(1) == 1);
      for (k = 0; k < len; k++) begin
         if ($urandom_range(99) < 8)
            push_request(8'($urandom), 1'b0, 1'b0);
         push_request(8'($urandom), 1'b1, tail_byte && (k == len - 1));
      end
      if (!tail_byte)
         push_request(8'($urandom), 1'b0, 1'b1);
   endtask

   // One long message to hit a padding boundary, then mostly short ones.
   task automatic run_phase(input int send_pct, input int recv_pct, input int long_len);
      int first_sent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first_sent    = requests_sent;
      send_message(long_len);
      while (requests_sent - first_sent < PHASE_TARGET)
         send_message(($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(0, 12));
   endtask

   // Sender stays quiet until every digest word has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (words_due != 0)
         @(negedge clock);
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.data_byte    = 8'h00;
      req_chan.byte_present = 1'b0;
      req_chan.message_end  = 1'b0;
      send_idle_pct         = 0;
      recv_idle_pct         = 0;
      rsp_hold_left         = 0;
      requests_sent         = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: empty message, byte carrying the end, ignored requests, data extremes
      push_request(8'h00, 1'b0, 1'b1);
      push_request(8'h00, 1'b1, 1'b1);
      push_request(8'hFF, 1'b0, 1'b0);
      push_request(8'hFF, 1'b1, 1'b0);
      push_request(8'h80, 1'b1, 1'b0);
      push_request(8'h5A, 1'b0, 1'b0);
      push_request(8'hA5, 1'b0, 1'b1);
      push_request(8'h01, 1'b1, 1'b0);
      push_request(8'h7F, 1'b1, 1'b0);
      push_request(8'hFE, 1'b1, 1'b1);

      // receiver holds off while several messages are offered; the engine must stall
      // its request side until the response channel drains
      req_chan.valid <= 1'b0;
      @(posedge clock);
      rsp_hold_left = HOLD_CYCLES;
      @(negedge clock);
      push_request(8'h61, 1'b1, 1'b0);
      push_request(8'h62, 1'b1, 1'b0);
      push_request(8'h63, 1'b1, 1'b0);
      push_request(8'h00, 1'b0, 1'b1);
      push_request(8'hC3, 1'b1, 1'b0);
      push_request(8'h3C, 1'b1, 1'b1);
      push_request(8'h99, 1'b1, 1'b0);
      push_request(8'h00, 1'b0, 1'b1);
      wait_drained();

      // random traffic: length field fits after 55 bytes, spills past 56..63,
      // full block with nothing left over at 64
      run_phase(22, 79, 55);
      run_phase(79, 22, $urandom_range(56, 63));
      run_phase(0, 0, 64);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
